/* hw/rtl/iom_pkg.sv */
// Shared types, sizes and helpers for the indeterminate order match block.
// Used by iom_cell, iom_pick and indeterminate_order_match_top.
package iom_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int MASK_BITS = 32;
  localparam int KEY_W     = 32;
  localparam int IN_MASK_W = 32;
  localparam int CNT_W     = $clog2(MAX_LEN + 1);

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [MASK_BITS-1:0]    mask_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EVAL = 2'b10
  } state_e;

  // Broadcast control for the sorting chain.
  typedef struct packed {
    logic  insert;
    logic  drain;
    key_t  key;
    mask_t mask;
  } chain_ctrl_t;

  // Keep the low MASK_BITS bits of an input mask, zero-filling above it.
  function automatic mask_t fit_mask(logic [IN_MASK_W-1:0] m);
    mask_t r;
    r = '0;
    for (int b = 0; b < MASK_BITS; b++) begin
      if (b < IN_MASK_W) begin
        r[b] = m[b];
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/iom_cell.sv */
// One cell of the insertion sorting chain: holds one key and its mask.
// Depends on iom_pkg.
module iom_cell import iom_pkg::*; (
  input  logic        clk_i,
  input  chain_ctrl_t ctrl_i,
  input  logic        occupied_i,
  input  logic        prev_greater_i,
  input  key_t        prev_key_i,
  input  mask_t       prev_mask_i,
  input  key_t        next_key_i,
  input  mask_t       next_mask_i,
  output logic        greater_o,
  output key_t        key_o,
  output mask_t       mask_o
);

  key_t  key_q, key_d;
  mask_t mask_q, mask_d;

  // empty cells sort as +inf; strict compare keeps ties in arrival order
  assign greater_o = !occupied_i || (key_q > ctrl_i.key);

  always_comb begin
    key_d  = key_q;
    mask_d = mask_q;
    if (ctrl_i.drain) begin
      key_d  = next_key_i;
      mask_d = next_mask_i;
    end else if (ctrl_i.insert && greater_o) begin
      if (prev_greater_i) begin
        key_d  = prev_key_i;
        mask_d = prev_mask_i;
      end else begin
        key_d  = ctrl_i.key;
        mask_d = ctrl_i.mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    mask_q <= mask_d;
  end

  assign key_o  = key_q;
  assign mask_o = mask_q;

endmodule

/* hw/rtl/iom_pick.sv */
// Greedy pick unit: lowest permitted one-hot value at or above the last pick.
// Depends on iom_pkg.
module iom_pick import iom_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  clear_i,
  input  logic  step_i,
  input  mask_t mask_i,
  output logic  ok_o
);

  mask_t prev_q, prev_d;
  mask_t avail;
  mask_t pick;

  assign avail = mask_i & ~(prev_q - mask_t'(1));
  assign pick  = avail & (~avail + mask_t'(1));
  assign ok_o  = |pick;

  always_comb begin
    prev_d = prev_q;
    if (clear_i) begin
      prev_d = mask_t'(1);
    end else if (step_i && ok_o) begin
      prev_d = pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= mask_t'(1);
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

/* hw/rtl/indeterminate_order_match_top.sv */
// Top level of the indeterminate order match block: sorting chain + pick unit.
// Depends on iom_pkg, iom_cell, iom_pick.
//
// Usage: a request (pattern_key_i, allowed_mask_i, last_item_i) is taken at a
// rising edge where start_i is high and busy_o is low. While loading, busy_o
// stays low and one request is taken per cycle; each key is inserted into a
// chain of MAX_LEN cells as it is taken, ties kept in arrival order. Requests
// beyond MAX_LEN are dropped and flagged.
// The request marked last starts evaluation: busy_o goes high and the chain
// shifts toward cell 0 one entry per cycle through the greedy pick unit.
// Evaluation steps through the N stored items and ends early on a mismatch.
// In the cycle after the final step, done_o pulses for one cycle with
// matched_o and overflowed_o; busy_o is already low in that cycle.
// The receiver cannot stall: the result is shown for exactly one cycle.
// Reset clears the item count, overflow flag, pick and state; cell contents
// are not reset and are only read below the item count.
module indeterminate_order_match_top import iom_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [31:0]   pattern_key_i,
  input  logic [31:0]          allowed_mask_i,
  input  logic                 last_item_i,
  output logic                 done_o,
  output logic                 matched_o,
  output logic                 overflowed_o
);

  state_e      state_q, state_d;
  cnt_t        count_q, count_d;
  cnt_t        remain_q, remain_d;
  logic        ovf_q, ovf_d;
  logic        done_q, done_d;
  logic        matched_q, matched_d;
  logic        ovfout_q, ovfout_d;

  logic        accept;
  logic        full;
  logic        pick_ok;
  logic        pick_clear;
  chain_ctrl_t ctrl;

  logic  greater [MAX_LEN];
  key_t  keys    [MAX_LEN];
  mask_t masks   [MAX_LEN];

  assign busy_o = (state_q != ST_LOAD);
  assign accept = start_i && !busy_o;
  assign full   = (count_q == cnt_t'(MAX_LEN));

  assign ctrl.insert = accept && !full;
  assign ctrl.drain  = (state_q == ST_EVAL);
  assign ctrl.key    = key_t'(pattern_key_i);
  assign ctrl.mask   = fit_mask(allowed_mask_i);

  assign pick_clear = accept && last_item_i;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic  occ;
    logic  pg;
    key_t  pk, nk;
    mask_t pm, nm;

    assign occ = (count_q > cnt_t'(i));

    if (i == 0) begin : g_first
      assign pg = 1'b0;
      assign pk = '0;
      assign pm = '0;
    end else begin : g_mid
      assign pg = greater[i-1];
      assign pk = keys[i-1];
      assign pm = masks[i-1];
    end

    if (i == MAX_LEN - 1) begin : g_last
      assign nk = keys[i];
      assign nm = masks[i];
    end else begin : g_inner
      assign nk = keys[i+1];
      assign nm = masks[i+1];
    end

    iom_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .occupied_i     (occ),
      .prev_greater_i (pg),
      .prev_key_i     (pk),
      .prev_mask_i    (pm),
      .next_key_i     (nk),
      .next_mask_i    (nm),
      .greater_o      (greater[i]),
      .key_o          (keys[i]),
      .mask_o         (masks[i])
    );
  end

  iom_pick u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (pick_clear),
    .step_i  (ctrl.drain),
    .mask_i  (masks[0]),
    .ok_o    (pick_ok)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    remain_d  = remain_q;
    ovf_d     = ovf_q;
    done_d    = 1'b0;
    matched_d = matched_q;
    ovfout_d  = ovfout_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + cnt_t'(1);
          end
          if (last_item_i) begin
            remain_d = count_d;
            state_d  = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (!pick_ok || remain_q == cnt_t'(1)) begin
          done_d    = 1'b1;
          matched_d = pick_ok;
          ovfout_d  = ovf_q;
          count_d   = '0;
          ovf_d     = 1'b0;
          state_d   = ST_LOAD;
        end else begin
          remain_d = remain_q - cnt_t'(1);
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      remain_q <= '0;
      ovf_q    <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      ovf_q    <= ovf_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    ovfout_q  <= ovfout_d;
  end

  assign done_o       = done_q;
  assign matched_o    = matched_q;
  assign overflowed_o = ovfout_q;

`ifndef ASSERT_OFF
  a_done_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_EVAL))
    else $error("result strobe without evaluation");

  a_eval_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (remain_q != '0))
    else $error("evaluation with no items left");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(MAX_LEN))
    else $error("item count beyond capacity");

  a_last_starts_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_item_i) |=> (busy_o && !done_o))
    else $error("last request did not start evaluation");
`endif

endmodule

/* tb/indeterminate_order_match_top_test.sv */
// Self-checking testbench for indeterminate_order_match_top: random and directed
// strings, a stable-sort and greedy-pick predictor, result compare per field.
// Depends on iom_pkg and the indeterminate_order_match_top RTL.
`timescale 1ns / 100ps

module indeterminate_order_match_top_test;
  import iom_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    key_t        key;
    logic [31:0] mask;
    logic        last;
    int unsigned idle_pct;
    bit          drain_first;
  } request_t;

  typedef struct {
    logic matched;
    logic overflowed;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  key_t        pattern_key_i = '0;
  logic [31:0] allowed_mask_i = '0;
  logic        last_item_i = 1'b0;
  logic        busy_o;
  logic        done_o;
  logic        matched_o;
  logic        overflowed_o;

  request_t    pending_requests[$];
  request_t    next_request;
  verdict_t    expected_verdicts[$];
  verdict_t    due_verdict;
  key_t        sorted_keys[$];
  mask_t       sorted_masks[$];
  bit          string_overflow = 1'b0;
  int unsigned send_idle_pct = 0;
  bit          drain_next = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  indeterminate_order_match_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .pattern_key_i (pattern_key_i),
    .allowed_mask_i(allowed_mask_i),
    .last_item_i   (last_item_i),
    .done_o        (done_o),
    .matched_o     (matched_o),
    .overflowed_o  (overflowed_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stable insertion by signed key; on the last request, greedy lowest pick.
  function automatic void absorb_request(key_t k, logic [31:0] m, logic last);
    int unsigned pos;
    mask_t       prev_pick;
    mask_t       avail;
    mask_t       pick;
    bit          ok;
    verdict_t    verdict;
    if (sorted_keys.size() < MAX_LEN) begin
      pos = sorted_keys.size();
      while (pos > 0 && sorted_keys[pos-1] > k) pos--;
      sorted_keys.insert(pos, k);
      sorted_masks.insert(pos, mask_t'(m));
    end else begin
      string_overflow = 1'b1;
    end
    if (last) begin
      ok = 1'b1;
      prev_pick = mask_t'(1);
      foreach (sorted_masks[i]) begin
        if (ok) begin
          avail = sorted_masks[i] & ~(prev_pick - mask_t'(1));
          pick = avail & (~avail + mask_t'(1));
          if (pick == '0) begin
            ok = 1'b0;
          end else begin
            prev_pick = pick;
          end
        end
      end
      verdict.matched = ok;
      verdict.overflowed = string_overflow;
      expected_verdicts.insert(expected_verdicts.size(), verdict);
      sorted_keys.delete();
      sorted_masks.delete();
      string_overflow = 1'b0;
    end
  endfunction

  task automatic add_item(input key_t k, input logic [31:0] m, input logic last);
    request_t req;
    req.key = k;
    req.mask = m;
    req.last = last;
    req.idle_pct = send_idle_pct;
    req.drain_first = drain_next;
    pending_requests.insert(pending_requests.size(), req);
    drain_next = 1'b0;
  endtask

  // clean: every position carries a bit that rises with the key, so a match exists.
  task automatic add_string(input int unsigned len, input bit narrow, input bit clean);
    key_t        k;
    logic [31:0] m;
    int unsigned b;
    for (int unsigned i = 0; i < len; i++) begin
      if (narrow) begin
        k = key_t'($urandom_range(6)) - key_t'(3);
        b = unsigned'((int'(k) + 3) * 4);
      end else begin
        k = key_t'($urandom);
        b = 32'({~k[31], k[30:27]});
      end
      m = $urandom & $urandom & $urandom;
      if (clean) begin
        m[b] = 1'b1;
      end else if ($urandom_range(9) == 0) begin
        m = '0;
      end else if ($urandom_range(1) == 1) begin
        m = $urandom;
      end
      add_item(k, m, i == len - 1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      pattern_key_i <= '0;
      allowed_mask_i <= '0;
      last_item_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        absorb_request(pattern_key_i, allowed_mask_i, last_item_i);
      end
      if (!start_i || !busy_o) begin
        if (pending_requests.size() == 0) begin
          start_i <= 1'b0;
        end else if (pending_requests[0].drain_first &&
                     (expected_verdicts.size() != 0 || done_o)) begin
          start_i <= 1'b0;
        end else if ($urandom_range(99) < pending_requests[0].idle_pct) begin
          start_i <= 1'b0;
        end else begin
          next_request = pending_requests.pop_front();
          pattern_key_i <= next_request.key;
          allowed_mask_i <= next_request.mask;
          last_item_i <= next_request.last;
          start_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: matched=%0b overflowed=%0b", matched_o, overflowed_o);
        end
      end else begin
        due_verdict = expected_verdicts.pop_front();
        if (due_verdict.matched !== matched_o || due_verdict.overflowed !== overflowed_o) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: matched exp %0b got %0b, overflowed exp %0b got %0b",
                     due_verdict.matched, matched_o, due_verdict.overflowed, overflowed_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("indeterminate_order_match_top test failed");
      $finish;
    end
  end

  initial begin
    int unsigned target;
    send_idle_pct = 8;
    // lone positions: widest keys, full and empty masks
    add_item(32'sh7FFFFFFF, 32'hFFFFFFFF, 1'b1);
    add_item(32'sh80000000, 32'h00000000, 1'b1);
    // most negative key picks the top bit, nothing left above it
    add_item(32'sh80000000, 32'h80000000, 1'b0);
    add_item(32'sh7FFFFFFF, 32'h00000001, 1'b1);
    // arrival order differs from key order
    add_item(32'sd5, 32'h00000008, 1'b0);
    add_item(-32'sd5, 32'h00000080, 1'b1);
    add_item(32'sd5, 32'h00000080, 1'b0);
    add_item(-32'sd5, 32'h00000008, 1'b1);
    // equal pick is allowed
    add_item(32'sd1, 32'h00000010, 1'b0);
    add_item(32'sd2, 32'h00000010, 1'b1);
    // equal keys stay in arrival order
    add_item(32'sd0, 32'h00000004, 1'b0);
    add_item(32'sd0, 32'h00000200, 1'b1);
    add_item(32'sd0, 32'h00000200, 1'b0);
    add_item(32'sd0, 32'h00000004, 1'b1);
    // greedy takes the lowest bit
    add_item(-32'sd1, 32'h00100002, 1'b0);
    add_item(32'sd1, 32'h00000020, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 49 : 0;
      drain_next = 1'b1;
      target = pending_requests.size() + 285;
      while (pending_requests.size() < target) begin
        add_string(($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1),
                   $urandom_range(2) == 0, $urandom_range(9) < 7);
      end
    end
    // one string past the store depth; its last two requests are dropped
    drain_next = 1'b1;
    add_string(MAX_LEN + 2, 1'b0, 1'b1);
    for (int n = 0; n < 6; n++) begin
      add_string($urandom_range(6, 1), 1'b0, 1'b1);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_requests.size() != 0 || start_i) @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("indeterminate_order_match_top test passed");
    end else begin
      $display("indeterminate_order_match_top test failed");
    end
    $finish;
  end

endmodule

/* indeterminate_order_match_top.f */
hw/rtl/iom_pkg.sv
hw/rtl/iom_cell.sv
hw/rtl/iom_pick.sv
hw/rtl/indeterminate_order_match_top.sv
tb/indeterminate_order_match_top_test.sv
